// ----- hdl/mie_pkg.sv -----
package mie_pkg;

  localparam int WIDTH   = 32;
  localparam int IN_W    = WIDTH - 1;            // value_a, modulus, gcd, inverse
  localparam int COEF_W  = WIDTH;                // coef_a, coef_m
  localparam int CW      = WIDTH + 2;            // working coefficient width, holds s1 << k
  localparam int KW      = $clog2(IN_W);         // shift count of the quotient search
  localparam int IN_TD_W = ((2 * IN_W + 7) / 8) * 8;
  localparam int OUT_TD_W = ((2 * COEF_W + 2 * IN_W + 7) / 8) * 8;
  localparam int PC_W    = 3;

  // Step addresses of the microprogram
  localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [PC_W-1:0] STEP_TOP  = 3'd1;
  localparam logic [PC_W-1:0] STEP_GROW = 3'd2;
  localparam logic [PC_W-1:0] STEP_SUB  = 3'd3;
  localparam logic [PC_W-1:0] STEP_SWAP = 3'd4;
  localparam logic [PC_W-1:0] STEP_FIXA = 3'd5;
  localparam logic [PC_W-1:0] STEP_FIXB = 3'd6;
  localparam logic [PC_W-1:0] STEP_EMIT = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GROW,
    OP_SUB,
    OP_SWAP,
    OP_FIXA,
    OP_FIXB,
    OP_EMIT
  } mie_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_WAIT_IN,
    COND_R1_ZERO,
    COND_CAN_GROW,
    COND_K_NONZERO,
    COND_REM_NONZERO,
    COND_OUT_BUSY
  } mie_cond_e;

  typedef struct packed {
    mie_op_e         op;
    mie_cond_e       cond;
    logic [PC_W-1:0] target;
  } mie_ctrl_t;

  // Microprogram: run op, then jump to target when cond holds, else step on.
  function automatic mie_ctrl_t mie_rom(input logic [PC_W-1:0] pc);
    mie_ctrl_t w;
    unique case (pc)
      STEP_IDLE: w = '{op: OP_LOAD, cond: COND_WAIT_IN,     target: STEP_IDLE};
      STEP_TOP:  w = '{op: OP_NOP,  cond: COND_R1_ZERO,     target: STEP_FIXA};
      STEP_GROW: w = '{op: OP_GROW, cond: COND_CAN_GROW,    target: STEP_GROW};
      STEP_SUB:  w = '{op: OP_SUB,  cond: COND_K_NONZERO,   target: STEP_SUB};
      STEP_SWAP: w = '{op: OP_SWAP, cond: COND_REM_NONZERO, target: STEP_GROW};
      STEP_FIXA: w = '{op: OP_FIXA, cond: COND_NEVER,       target: STEP_IDLE};
      STEP_FIXB: w = '{op: OP_FIXB, cond: COND_NEVER,       target: STEP_IDLE};
      STEP_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_BUSY,    target: STEP_EMIT};
      default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,      target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/modular_inverse_extended_euclid.sv -----
// Modular inverse by the extended Euclidean algorithm.
//
// Input channel (s_axis): one beat carries value_a and modulus. Output channel
// (m_axis): one beat per input beat carries the Bezout coefficients coef_a and
// coef_m (a*coef_a + m*coef_m = gcd), the gcd, the inverse of value_a reduced
// into 0..modulus-1, and has_inverse in tuser. Zero modulus gives coef_a=1,
// coef_m=0, gcd=value_a and no inverse.
//
// A small microprogram drives one shift-and-subtract datapath. Each Euclid
// iteration finds its quotient q bit by bit: the divisor is doubled while it
// fits (k = floor(log2 q) doublings), then walked back down with a conditional
// subtract of remainder and both coefficients per step. Small operands
// finish far sooner than full-width ones. One item is worked on at a time;
// s_axis_tready_o is high only while the sequencer waits at its idle step.
//
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and computed, and the sequencer holds at its
// last step until the register frees. Reset empties the output register and
// returns the sequencer to idle.
module modular_inverse_extended_euclid
  import mie_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // value_a [30:0], modulus [61:31], zero [63:62]
  input  logic [IN_TD_W-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // coef_a [31:0], coef_m [63:32], gcd_value [94:64], inverse [125:95], zero [127:126]
  output logic [OUT_TD_W-1:0] m_axis_tdata_o,
  // has_inverse [0]
  output logic                m_axis_tuser_o
);

  localparam int OUT_PAD = OUT_TD_W - 2 * COEF_W - 2 * IN_W;

  logic [PC_W-1:0] pc_q, pc_d;
  mie_ctrl_t       ctrl;

  logic [IN_W-1:0]      r0_q, r0_d, r1_q, r1_d, m_q, m_d, d_q, d_d;
  logic signed [CW-1:0] s0_q, s0_d, s1_q, s1_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [CW-1:0] ds_q, ds_d, dt_q, dt_d, inv_q, inv_d;
  logic [KW-1:0]        k_q, k_d;

  logic                 out_valid_q, out_valid_d;
  logic [COEF_W-1:0]    o_coef_a_q, o_coef_a_d, o_coef_m_q, o_coef_m_d;
  logic [IN_W-1:0]      o_gcd_q, o_gcd_d, o_inv_q, o_inv_d;
  logic                 o_has_q, o_has_d;

  logic                 in_beat, can_grow, r0_ge_d, inv_ok, out_busy, cond_hit;
  logic signed [CW-1:0] m_ext;

  assign ctrl      = mie_rom(pc_q);
  assign s_axis_tready_o = (pc_q == STEP_IDLE);
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_grow  = ({d_q, 1'b0} <= {1'b0, r0_q});
  assign r0_ge_d   = (r0_q >= d_q);
  assign inv_ok    = (r0_q == {{(IN_W-1){1'b0}}, 1'b1}) && (m_q != '0);
  assign out_busy  = out_valid_q && !m_axis_tready_i;
  assign m_ext     = {{(CW-IN_W){1'b0}}, m_q};

  // Sequencer: jump condition select
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:       cond_hit = 1'b0;
      COND_ALWAYS:      cond_hit = 1'b1;
      COND_WAIT_IN:     cond_hit = !s_axis_tvalid_i;
      COND_R1_ZERO:     cond_hit = (r1_q == '0);
      COND_CAN_GROW:    cond_hit = can_grow;
      COND_K_NONZERO:   cond_hit = (k_q != '0);
      COND_REM_NONZERO: cond_hit = (r0_q != '0);
      COND_OUT_BUSY:    cond_hit = out_busy;
      default:          cond_hit = 1'b0;
    endcase
  end

  // Last step wraps back to idle
  always_comb begin
    pc_d = cond_hit ? ctrl.target : pc_q + 1'b1;
  end

  // Datapath
  always_comb begin
    r0_d  = r0_q;
    r1_d  = r1_q;
    m_d   = m_q;
    d_d   = d_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    t0_d  = t0_q;
    t1_d  = t1_q;
    ds_d  = ds_q;
    dt_d  = dt_q;
    k_d   = k_q;
    inv_d = inv_q;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_beat) begin
          r0_d = s_axis_tdata_i[IN_W-1:0];
          r1_d = s_axis_tdata_i[2*IN_W-1:IN_W];
          m_d  = s_axis_tdata_i[2*IN_W-1:IN_W];
          d_d  = s_axis_tdata_i[2*IN_W-1:IN_W];
          s0_d = CW'(1);
          s1_d = '0;
          t0_d = '0;
          t1_d = CW'(1);
          ds_d = '0;
          dt_d = CW'(1);
          k_d  = '0;
        end
      end
      OP_GROW: begin
        if (can_grow) begin
          d_d  = {d_q[IN_W-2:0], 1'b0};
          ds_d = ds_q <<< 1;
          dt_d = dt_q <<< 1;
          k_d  = k_q + 1'b1;
        end
      end
      OP_SUB: begin
        if (r0_ge_d) begin
          r0_d = r0_q - d_q;
          s0_d = s0_q - ds_q;
          t0_d = t0_q - dt_q;
        end
        d_d  = d_q >> 1;
        ds_d = ds_q >>> 1;
        dt_d = dt_q >>> 1;
        k_d  = k_q - 1'b1;
      end
      OP_SWAP: begin
        // r0 holds the new remainder; it becomes the next divisor
        r0_d = r1_q;
        r1_d = r0_q;
        s0_d = s1_q;
        s1_d = s0_q;
        t0_d = t1_q;
        t1_d = t0_q;
        d_d  = r0_q;
        ds_d = s0_q;
        dt_d = t0_q;
        k_d  = '0;
      end
      OP_FIXA: begin
        inv_d = s0_q + (s0_q[CW-1] ? m_ext : '0);
      end
      OP_FIXB: begin
        if (!inv_ok) begin
          inv_d = '0;
        end else if (inv_q >= m_ext) begin
          inv_d = inv_q - m_ext;
        end
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    o_coef_a_d  = o_coef_a_q;
    o_coef_m_d  = o_coef_m_q;
    o_gcd_d     = o_gcd_q;
    o_inv_d     = o_inv_q;
    o_has_d     = o_has_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid_d = 1'b1;
      o_coef_a_d  = s0_q[COEF_W-1:0];
      o_coef_m_d  = t0_q[COEF_W-1:0];
      o_gcd_d     = r0_q;
      o_inv_d     = inv_q[IN_W-1:0];
      o_has_d     = inv_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    m_q        <= m_d;
    d_q        <= d_d;
    s0_q       <= s0_d;
    s1_q       <= s1_d;
    t0_q       <= t0_d;
    t1_q       <= t1_d;
    ds_q       <= ds_d;
    dt_q       <= dt_d;
    k_q        <= k_d;
    inv_q      <= inv_d;
    o_coef_a_q <= o_coef_a_d;
    o_coef_m_q <= o_coef_m_d;
    o_gcd_q    <= o_gcd_d;
    o_inv_q    <= o_inv_d;
    o_has_q    <= o_has_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, o_inv_q, o_gcd_q, o_coef_m_q, o_coef_a_q};
  assign m_axis_tuser_o  = o_has_q;

  // A fresh result is loaded only from the emit step
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == STEP_EMIT))
    else $error("result loaded outside emit step");

  // Each quotient search leaves a remainder below its divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_SWAP) |-> (r0_q < r1_q))
    else $error("remainder not below divisor");

  // Quotient shift never runs past the operand width
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_GROW || pc_q == STEP_SUB) |-> (k_q < KW'(IN_W)))
    else $error("quotient shift out of range");

  // An inverse is reported only with gcd one and a reduced value below modulus
  a_inv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_EMIT && inv_ok) |-> (inv_q >= '0 && inv_q < m_ext))
    else $error("inverse not reduced");

  // Without an inverse the reduced field is cleared
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_has_q) |-> (o_inv_q == '0))
    else $error("inverse field set without inverse");

endmodule
